// ===== hdl/cdcu_pkg.sv =====
// ---------------------------------------------------------------------------
// Countdown / count-up time display: shared package
// Widths, codes, item types and constants used across the core.
// ---------------------------------------------------------------------------
`default_nettype none

package cdcu_pkg;

   // Time arithmetic width (times are taken modulo 2^TIME_WIDTH)
   localparam int TIME_WIDTH       = 32;

   // Port field widths
   localparam int NOW_WIDTH        = 32;
   localparam int TARGET_WIDTH     = 32;
   localparam int THRESH_WIDTH     = 16;
   localparam int BLINK_WIDTH      = 8;
   localparam int FLASH_WIDTH      = 9;
   localparam int DAYS_WIDTH       = 16;
   localparam int HOURS_WIDTH      = 5;
   localparam int MINUTES_WIDTH    = 6;
   localparam int SECS_WIDTH       = 6;
   localparam int REQ_DATA_WIDTH   = 32;
   localparam int RSP_DATA_WIDTH   = 40;
   localparam int CSR_ADDR_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH   = 32;

   // Seconds per unit
   localparam int SECS_PER_DAY     = 86400;
   localparam int SECS_PER_HOUR    = 3600;
   localparam int SECS_PER_MIN     = 60;

   // Register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TARGET    = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_BLINK     = 2'd2;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd10;

   typedef enum logic [1:0] {
      STATUS_TIME     = 2'd0,
      STATUS_INVERT   = 2'd1,
      STATUS_PLAIN    = 2'd2,
      STATUS_FINISHED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      LAYOUT_SS       = 2'd0,
      LAYOUT_MMSS     = 2'd1,
      LAYOUT_HHMMSS   = 2'd2,
      LAYOUT_DHHMMSS  = 2'd3
   } layout_type;

   typedef logic [TIME_WIDTH-1:0] time_type;

   // Day quotient: 86400 > 2^16, so the quotient fits TIME_WIDTH-16 bits
   localparam int DAYQ_WIDTH     = TIME_WIDTH - 16;
   localparam int DAYX_WIDTH     = (DAYQ_WIDTH > DAYS_WIDTH) ? DAYQ_WIDTH : DAYS_WIDTH;
   localparam int DAY_PROD_WIDTH = TIME_WIDTH + DAYQ_WIDTH;
   localparam int DAY_REM_WIDTH  = 17;   // below 86400
   localparam int HOUR_REM_WIDTH = 12;   // below 3600

   typedef logic [DAYQ_WIDTH-1:0]     dayq_type;
   typedef logic [DAYX_WIDTH-1:0]     dayx_type;
   typedef logic [DAY_PROD_WIDTH-1:0] day_prod_type;
   typedef logic [DAY_REM_WIDTH-1:0]  day_rem_type;
   typedef logic [HOUR_REM_WIDTH-1:0] hour_rem_type;
   typedef logic [DAYS_WIDTH-1:0]     days_type;
   typedef logic [SECS_WIDTH-1:0]     secs_type;

   // Reciprocal floor(2^TIME_WIDTH / 86400); quotient estimate is low by at most one
   localparam logic [TIME_WIDTH:0] DAY_SCALE      = (TIME_WIDTH+1)'(1) << TIME_WIDTH;
   localparam logic [TIME_WIDTH:0] DAY_RECIP_FULL = DAY_SCALE / (TIME_WIDTH+1)'(SECS_PER_DAY);
   localparam dayq_type            DAY_RECIP      = DAY_RECIP_FULL[DAYQ_WIDTH-1:0];

   // Front to back queue
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic [QUEUE_PTR_WIDTH-1:0] queue_ptr_type;
   typedef logic [QUEUE_CNT_WIDTH-1:0] queue_cnt_type;

   // One classified item: status, critical flag and duration to split
   typedef struct packed {
      status_type status;
      logic       critical;
      time_type   duration;
   } job_type;

   function automatic time_type now_to_time(input logic [NOW_WIDTH-1:0] v);
      return time_type'(v);
   endfunction

   function automatic time_type thr_to_time(input logic [THRESH_WIDTH-1:0] v);
      return time_type'(v);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/cdcu_front.sv =====
// ---------------------------------------------------------------------------
// Countdown / count-up time display: front end
// Holds the registers and tick state, classifies each tick into a job.
// ---------------------------------------------------------------------------
`default_nettype none

module cdcu_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // register write port
   input  wire logic                                  csr_we,
   input  wire logic [cdcu_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  wire logic [cdcu_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   // tick items
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [cdcu_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,   // [31:0] now_seconds
   // jobs to queue
   output logic                                       job_valid,
   input  wire logic                                  job_ready,
   output cdcu_pkg::job_type                          job
);

   logic [cdcu_pkg::TARGET_WIDTH-1:0] target_ff;
   logic [cdcu_pkg::THRESH_WIDTH-1:0] threshold_ff;
   logic [cdcu_pkg::BLINK_WIDTH-1:0]  blink_ff;
   cdcu_pkg::time_type                start_ff, start_in;
   logic                              start_valid_ff, start_valid_in;
   logic [cdcu_pkg::FLASH_WIDTH-1:0]  flash_ff, flash_in;

   cdcu_pkg::time_type now_t;
   cdcu_pkg::time_type tgt_t;
   cdcu_pkg::time_type base_t;
   cdcu_pkg::time_type dur_t;
   logic               accept;

   assign now_t      = cdcu_pkg::now_to_time(req_tdata[cdcu_pkg::NOW_WIDTH-1:0]);
   assign tgt_t      = cdcu_pkg::now_to_time(target_ff);
   assign job_valid  = req_tvalid;
   assign req_tready = job_ready;
   assign accept     = req_tvalid && job_ready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         threshold_ff <= cdcu_pkg::THRESH_RESET;
         blink_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            cdcu_pkg::CSR_TARGET:    target_ff    <= csr_wdata[cdcu_pkg::TARGET_WIDTH-1:0];
            cdcu_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata[cdcu_pkg::THRESH_WIDTH-1:0];
            cdcu_pkg::CSR_BLINK:     blink_ff     <= csr_wdata[cdcu_pkg::BLINK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Classify the tick: countdown, expiry flashing, finished, or count-up
   always_comb begin
      job            = '{status: cdcu_pkg::STATUS_TIME, critical: 1'b0, duration: '0};
      start_in       = start_ff;
      start_valid_in = start_valid_ff;
      flash_in       = flash_ff;
      base_t         = start_valid_ff ? start_ff : now_t;
      dur_t          = '0;
      if (tgt_t != '0) begin
         if (now_t < tgt_t) begin
            dur_t        = tgt_t - now_t;
            job.duration = dur_t;
            job.critical = (threshold_ff != '0) &&
                           (dur_t <= cdcu_pkg::thr_to_time(threshold_ff));
         end else if (flash_ff < {blink_ff, 1'b0}) begin
            // even flashes inverted, odd ones plain
            job.status = flash_ff[0] ? cdcu_pkg::STATUS_PLAIN : cdcu_pkg::STATUS_INVERT;
            flash_in   = flash_ff + 1'b1;
         end else begin
            job.status = cdcu_pkg::STATUS_FINISHED;
         end
      end else begin
         // count-up, start latched on first tick; elapsed saturates at zero
         start_in       = base_t;
         start_valid_in = 1'b1;
         if (now_t >= base_t) begin
            dur_t = now_t - base_t;
         end
         job.duration = dur_t;
      end
   end

   // Tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_valid_ff <= 1'b0;
         flash_ff       <= '0;
      end else if (accept) begin
         start_valid_ff <= start_valid_in;
         flash_ff       <= flash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= start_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cdcu_queue.sv =====
// ---------------------------------------------------------------------------
// Countdown / count-up time display: job queue
// Short flip-flop FIFO, front to back; push and pop share a cycle unless full or empty.
// ---------------------------------------------------------------------------
`default_nettype none

module cdcu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire cdcu_pkg::job_type in_job,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output cdcu_pkg::job_type      out_job
);

   cdcu_pkg::job_type       entry_ff [cdcu_pkg::QUEUE_DEPTH];
   cdcu_pkg::queue_ptr_type wr_ptr_ff, wr_ptr_in;
   cdcu_pkg::queue_ptr_type rd_ptr_ff, rd_ptr_in;
   cdcu_pkg::queue_cnt_type count_ff, count_in;
   logic                    push;
   logic                    pop;

   assign in_ready  = (count_ff != cdcu_pkg::queue_cnt_type'(cdcu_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count (depth is a power of two, pointers wrap)
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cdcu_back.sv =====
// ---------------------------------------------------------------------------
// Countdown / count-up time display: back end
// Five-stage pipeline splitting a duration into days, hours, minutes, secs.
// ---------------------------------------------------------------------------
`default_nettype none

module cdcu_back (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   output logic                                      job_pop,
   input  wire cdcu_pkg::job_type                    job,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [1:0] status, [17:2] days, [22:18] hours, [28:23] minutes,
   // [34:29] secs, [36:35] layout, [37] critical, [39:38] zero
   output logic [cdcu_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata
);

   // Stage 1: reciprocal product for the day quotient
   logic                         v1_ff;
   cdcu_pkg::status_type         st1_ff;
   logic                         cr1_ff;
   cdcu_pkg::time_type           d1_ff;
   cdcu_pkg::day_prod_type       p1_ff, p1_in;
   // Stage 2: quotient estimate and its multiple of 86400
   logic                         v2_ff;
   cdcu_pkg::status_type         st2_ff;
   logic                         cr2_ff;
   cdcu_pkg::time_type           d2_ff;
   cdcu_pkg::dayq_type           q2_ff, q2_in;
   cdcu_pkg::time_type           c2_ff, c2_in;
   // Stage 3: corrected days and remainder of the day
   logic                         v3_ff;
   cdcu_pkg::status_type         st3_ff;
   logic                         cr3_ff;
   cdcu_pkg::dayq_type           days3_ff, days3_in;
   cdcu_pkg::day_rem_type        rd3_ff, rd3_in;
   // Stage 4: hours and remainder of the hour
   logic                         v4_ff;
   cdcu_pkg::status_type         st4_ff;
   logic                         cr4_ff;
   cdcu_pkg::dayq_type           days4_ff;
   logic [cdcu_pkg::HOURS_WIDTH-1:0] hours4_ff, hours4_in;
   cdcu_pkg::hour_rem_type       rh4_ff, rh4_in;
   // Stage 5: output register
   logic                         v5_ff;
   cdcu_pkg::status_type         st5_ff;
   logic                         cr5_ff;
   cdcu_pkg::days_type           days5_ff, days5_in;
   logic [cdcu_pkg::HOURS_WIDTH-1:0]   hours5_ff;
   logic [cdcu_pkg::MINUTES_WIDTH-1:0] min5_ff, min5_in;
   cdcu_pkg::secs_type           sec5_ff, sec5_in;
   cdcu_pkg::layout_type         lay5_ff, lay5_in;

   cdcu_pkg::time_type           r3;
   cdcu_pkg::day_rem_type        rem_h;
   cdcu_pkg::hour_rem_type       rem_m;
   cdcu_pkg::dayx_type           days_x;
   logic                         adv;

   // Whole pipeline moves together when the output register frees up
   assign adv     = !v5_ff || rsp_tready;
   assign job_pop = adv && job_valid;

   // Stage 1 logic
   assign p1_in = cdcu_pkg::day_prod_type'(job.duration) *
                  cdcu_pkg::day_prod_type'(cdcu_pkg::DAY_RECIP);

   // Stage 2 logic
   assign q2_in = p1_ff[cdcu_pkg::TIME_WIDTH +: cdcu_pkg::DAYQ_WIDTH];
   assign c2_in = cdcu_pkg::time_type'(q2_in) *
                  cdcu_pkg::time_type'(cdcu_pkg::SECS_PER_DAY);

   // Stage 3 logic: estimate is low by at most one day
   always_comb begin
      r3 = d2_ff - c2_ff;
      if (r3 >= cdcu_pkg::time_type'(cdcu_pkg::SECS_PER_DAY)) begin
         days3_in = q2_ff + 1'b1;
         rd3_in   = cdcu_pkg::day_rem_type'(r3 - cdcu_pkg::time_type'(cdcu_pkg::SECS_PER_DAY));
      end else begin
         days3_in = q2_ff;
         rd3_in   = cdcu_pkg::day_rem_type'(r3);
      end
   end

   // Stage 4 logic: restoring division by 3600, one quotient bit a step
   always_comb begin
      rem_h     = rd3_ff;
      hours4_in = '0;
      for (int b = cdcu_pkg::HOURS_WIDTH - 1; b >= 0; b--) begin
         if (rem_h >= (cdcu_pkg::day_rem_type'(cdcu_pkg::SECS_PER_HOUR) << b)) begin
            rem_h         = rem_h - (cdcu_pkg::day_rem_type'(cdcu_pkg::SECS_PER_HOUR) << b);
            hours4_in[b]  = 1'b1;
         end
      end
      rh4_in = cdcu_pkg::hour_rem_type'(rem_h);
   end

   // Stage 5 logic: minutes by restoring division, layout, day saturation
   always_comb begin
      rem_m   = rh4_ff;
      min5_in = '0;
      for (int b = cdcu_pkg::MINUTES_WIDTH - 1; b >= 0; b--) begin
         if (rem_m >= (cdcu_pkg::hour_rem_type'(cdcu_pkg::SECS_PER_MIN) << b)) begin
            rem_m      = rem_m - (cdcu_pkg::hour_rem_type'(cdcu_pkg::SECS_PER_MIN) << b);
            min5_in[b] = 1'b1;
         end
      end
      sec5_in = cdcu_pkg::secs_type'(rem_m);

      days_x = cdcu_pkg::dayx_type'(days4_ff);
      if (days_x > cdcu_pkg::dayx_type'({cdcu_pkg::DAYS_WIDTH{1'b1}})) begin
         days5_in = '1;
      end else begin
         days5_in = cdcu_pkg::days_type'(days_x);
      end

      if (days4_ff != '0) begin
         lay5_in = cdcu_pkg::LAYOUT_DHHMMSS;
      end else if (hours4_ff != '0) begin
         lay5_in = cdcu_pkg::LAYOUT_HHMMSS;
      end else if (min5_in != '0) begin
         lay5_in = cdcu_pkg::LAYOUT_MMSS;
      end else begin
         lay5_in = cdcu_pkg::LAYOUT_SS;
      end
   end

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= job_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         st1_ff    <= job.status;
         cr1_ff    <= job.critical;
         d1_ff     <= job.duration;
         p1_ff     <= p1_in;

         st2_ff    <= st1_ff;
         cr2_ff    <= cr1_ff;
         d2_ff     <= d1_ff;
         q2_ff     <= q2_in;
         c2_ff     <= c2_in;

         st3_ff    <= st2_ff;
         cr3_ff    <= cr2_ff;
         days3_ff  <= days3_in;
         rd3_ff    <= rd3_in;

         st4_ff    <= st3_ff;
         cr4_ff    <= cr3_ff;
         days4_ff  <= days3_ff;
         hours4_ff <= hours4_in;
         rh4_ff    <= rh4_in;

         st5_ff    <= st4_ff;
         cr5_ff    <= cr4_ff;
         days5_ff  <= days5_in;
         hours5_ff <= hours4_ff;
         min5_ff   <= min5_in;
         sec5_ff   <= sec5_in;
         lay5_ff   <= lay5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {2'b00, cr5_ff, lay5_ff, sec5_ff, min5_ff, hours5_ff, days5_ff, st5_ff};

endmodule

`default_nettype wire

// ===== hdl/countdown_countup_time_display_core.sv =====
// ---------------------------------------------------------------------------
// Countdown / count-up time display core
// Turns time ticks into a day/hour/minute/second display item per tick.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req_     | in        | req_tvalid/req_tready  | now_seconds
//  rsp_     | out       | rsp_tvalid/rsp_tready  | status, days, hours, minutes, secs,
//           |           |                        | layout, critical
//  csr_     | in        | csr_we                 | register index and data
//
//  One tick per cycle sustained while rsp_tready stays high. The front
//  classifies a tick in the cycle it is taken; a two-entry queue and a
//  five-stage split pipeline follow, and rsp_tvalid rises once the tick
//  reaches the output register of the back end. The day split is a reciprocal
//  multiply with one correction; hours and minutes take restoring steps.
//  Reset clears tick state, all valid flags and registers; threshold resets to 10.
//  A stalled output holds the pipeline; the queue absorbs two more ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module countdown_countup_time_display_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [cdcu_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire logic [cdcu_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [cdcu_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [31:0] now_seconds
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [1:0] status, [17:2] days, [22:18] hours, [28:23] minutes,
   // [34:29] secs, [36:35] layout, [37] critical, [39:38] zero
   output logic [cdcu_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata
);

   logic              fq_valid, fq_ready;
   cdcu_pkg::job_type fq_job;
   logic              qb_valid, qb_pop;
   cdcu_pkg::job_type qb_job;

   cdcu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .job_valid  (fq_valid),
      .job_ready  (fq_ready),
      .job        (fq_job)
   );

   cdcu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_pop),
      .out_job   (qb_job)
   );

   cdcu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_pop    (qb_pop),
      .job        (qb_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
